>>> design/pcf_pkg.sv
// Shared constants and coefficient tables for the polyphase channelizer front end.
// No dependencies.
package pcf_pkg;

    localparam int CHANNELS    = 16;
    localparam int TAPS        = 10;
    localparam int PHASES      = 4;
    localparam int SAMPLE_BITS = 12;
    localparam int OUT_BITS    = 28;

    localparam int CH_W    = $clog2(CHANNELS);
    localparam int TAP_W   = $clog2(TAPS);
    localparam int PH_W    = $clog2(PHASES);
    localparam int ROT_W   = 6;                          // rotation terms span -31..31
    localparam int H_W     = 10;                         // FIR taps span -85..511
    localparam int MIX_W   = SAMPLE_BITS + ROT_W - 1;    // exact mixer product
    localparam int MUL_W   = MIX_W + H_W;                // exact tap product
    localparam int DEPTH   = CHANNELS * TAPS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int DIN_W   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int DOUT_W  = ((2 * OUT_BITS + 7) / 8) * 8;

    typedef logic signed [ROT_W-1:0] rot_t;
    typedef logic signed [H_W-1:0]   coef_t;

    localparam rot_t ROT_RE [CHANNELS] = '{
        6'sd31, 6'sd31, 6'sd31, 6'sd30, 6'sd29, 6'sd28, 6'sd26, 6'sd24,
        6'sd22, 6'sd20, 6'sd17, 6'sd15, 6'sd12, 6'sd9,  6'sd6,  6'sd3
    };
    localparam rot_t ROT_IM [CHANNELS] = '{
        6'sd0,  6'sd3,  6'sd6,  6'sd9,  6'sd12, 6'sd15, 6'sd17, 6'sd20,
        6'sd22, 6'sd24, 6'sd26, 6'sd28, 6'sd29, 6'sd30, 6'sd31, 6'sd31
    };

    localparam coef_t H_TAB [CHANNELS][TAPS] = '{
        '{ -10'sd5,  10'sd21,   10'sd3, -10'sd84, 10'sd200, 10'sd511,
           10'sd170, -10'sd85,  10'sd8,  10'sd19 },
        '{  10'sd0,  10'sd23,  -10'sd3, -10'sd82, 10'sd230, 10'sd507,
           10'sd141, -10'sd85, 10'sd13,  10'sd17 },
        '{  10'sd1,  10'sd25, -10'sd10, -10'sd77, 10'sd260, 10'sd500,
           10'sd113, -10'sd82, 10'sd17,  10'sd15 },
        '{  10'sd1,  10'sd26, -10'sd17, -10'sd70, 10'sd289, 10'sd491,
           10'sd86,  -10'sd79, 10'sd21,  10'sd13 },
        '{  10'sd2,  10'sd27, -10'sd24, -10'sd62, 10'sd318, 10'sd478,
           10'sd61,  -10'sd74, 10'sd24,  10'sd11 },
        '{  10'sd2,  10'sd28, -10'sd32, -10'sd50, 10'sd347, 10'sd462,
           10'sd37,  -10'sd68, 10'sd26,  10'sd9 },
        '{  10'sd3,  10'sd29, -10'sd40, -10'sd37, 10'sd373, 10'sd443,
           10'sd16,  -10'sd62, 10'sd28,  10'sd8 },
        '{  10'sd5,  10'sd29, -10'sd47, -10'sd22, 10'sd399, 10'sd422,
           -10'sd4,  -10'sd55, 10'sd29,  10'sd6 },
        '{  10'sd6,  10'sd29, -10'sd55,  -10'sd4, 10'sd422, 10'sd399,
           -10'sd22, -10'sd47, 10'sd29,  10'sd5 },
        '{  10'sd8,  10'sd28, -10'sd62,  10'sd16, 10'sd443, 10'sd373,
           -10'sd37, -10'sd40, 10'sd29,  10'sd3 },
        '{  10'sd9,  10'sd26, -10'sd68,  10'sd37, 10'sd462, 10'sd347,
           -10'sd50, -10'sd32, 10'sd28,  10'sd2 },
        '{  10'sd11, 10'sd24, -10'sd74,  10'sd61, 10'sd478, 10'sd318,
           -10'sd62, -10'sd24, 10'sd27,  10'sd2 },
        '{  10'sd13, 10'sd21, -10'sd79,  10'sd86, 10'sd491, 10'sd289,
           -10'sd70, -10'sd17, 10'sd26,  10'sd1 },
        '{  10'sd15, 10'sd17, -10'sd82, 10'sd113, 10'sd500, 10'sd260,
           -10'sd77, -10'sd10, 10'sd25,  10'sd1 },
        '{  10'sd17, 10'sd13, -10'sd85, 10'sd141, 10'sd507, 10'sd230,
           -10'sd82,  -10'sd3, 10'sd23,  10'sd0 },
        '{  10'sd19, 10'sd8,  -10'sd85, 10'sd170, 10'sd511, 10'sd200,
           -10'sd84,   10'sd3, 10'sd21, -10'sd5 }
    };

endpackage

>>> design/polyphase_channelizer_front_core.sv
// Polyphase channelizer front end: quarter-turn mixer, per-channel rotation and
// per-channel 10-tap complex FIR. Depends on pcf_pkg.
//
// Usage
//   Input stream (s_*): one real signed sample per item, channel-interleaved;
//   items 0..15 after reset are channels 0..15 of the first frame, and so on.
//   Output stream (m_*): one complex FIR result per input item, in order, with
//   the channel number on m_tuser and m_tlast marking channel 15.
//   One item is processed at a time. One shared pair of tap multipliers walks
//   the 10 taps of a channel, one tap per cycle, fed by the single read port
//   of the delay-line memory; write-back of the newest sample runs with tap 0.
//   Steps after accept: mix, tap walk, last add, load of the output register.
//   The delay lines live in one 160-entry memory; a frame pointer marks the
//   newest slot of every channel, so no data moves on a shift.
//   Reset: channel slot, mixer phase, frame pointer and a fill count go to
//   zero. Taps older than the number of frames seen since reset read as zero,
//   so the memory needs no clearing pass and the block is ready at once.
//   Stall: s_tready is low while an item is in flight. A finished result
//   waits in the output register while the next item is accepted and
//   processed; a new result is held until the previous one has been taken.
module polyphase_channelizer_front_core
    import pcf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DIN_W-1:0]  s_tdata,   // [11:0] sample, rest zero
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DOUT_W-1:0] m_tdata,   // [27:0] out_real, [55:28] out_imag
    output logic [CH_W-1:0]   m_tuser,   // [3:0] out_channel
    output logic              m_tlast    // frame_last
);

    typedef enum logic [2:0] {S_IDLE, S_MIX, S_MAC, S_TAIL, S_OUT} state_t;

    typedef logic signed [MIX_W-1:0] mix_t;

    // global position in the stream
    state_t              state_reg;
    logic [CH_W-1:0]     slot_reg;
    logic [PH_W-1:0]     phase_reg;
    logic [TAP_W-1:0]    wpos_reg;      // delay-line slot written this frame
    logic [TAP_W-1:0]    fill_reg;      // frames seen since reset, saturates

    // item in flight
    logic signed [SAMPLE_BITS-1:0] samp_reg;
    logic [CH_W-1:0]     ich_reg;
    logic [PH_W-1:0]     iph_reg;
    logic [TAP_W-1:0]    ipos_reg;
    logic [TAP_W-1:0]    ifill_reg;
    logic [TAP_W-1:0]    k_reg;
    mix_t                mix_re_reg;
    mix_t                mix_im_reg;
    logic signed [MUL_W-1:0] mul_re_reg;
    logic signed [MUL_W-1:0] mul_im_reg;
    logic                mul_vld_reg;
    logic signed [OUT_BITS-1:0] acc_re_reg;
    logic signed [OUT_BITS-1:0] acc_im_reg;

    // output register
    logic                out_vld_reg;
    logic signed [OUT_BITS-1:0] out_re_reg;
    logic signed [OUT_BITS-1:0] out_im_reg;
    logic [CH_W-1:0]     out_ch_reg;
    logic                out_last_reg;

    // delay-line memory, {imag, real} per entry
    logic [2*MIX_W-1:0]  dl_mem [DEPTH];
    logic [2*MIX_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic                wr_en;

    logic                in_acc;
    rot_t                cre;
    rot_t                cim;
    logic signed [MIX_W:0] prod_re;
    logic signed [MIX_W:0] prod_im;
    logic [TAP_W:0]      rd_tap_sum;
    logic [TAP_W-1:0]    rd_tap;
    mix_t                op_re;
    mix_t                op_im;
    logic signed [MUL_W-1:0] mul_re;
    logic signed [MUL_W-1:0] mul_im;
    logic signed [OUT_BITS-1:0] mul_re_ext;
    logic signed [OUT_BITS-1:0] mul_im_ext;
    coef_t               h;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // quarter-turn term times channel rotation: (1,0) (0,-1) (-1,0) (0,1)
    always_comb
    begin
        unique case (iph_reg)
            2'd0:
            begin
                cre = ROT_RE[ich_reg];
                cim = ROT_IM[ich_reg];
            end
            2'd1:
            begin
                cre = ROT_IM[ich_reg];
                cim = -ROT_RE[ich_reg];
            end
            2'd2:
            begin
                cre = -ROT_RE[ich_reg];
                cim = -ROT_IM[ich_reg];
            end
            default:
            begin
                cre = -ROT_IM[ich_reg];
                cim = ROT_RE[ich_reg];
            end
        endcase
    end

    assign prod_re = samp_reg * cre;
    assign prod_im = samp_reg * cim;

    // tap k+1 is read while tap k is multiplied
    always_comb
    begin
        rd_tap_sum = {1'b0, ipos_reg} + (TAP_W+1)'(TAPS - 1) - {1'b0, k_reg};
        if (rd_tap_sum >= (TAP_W+1)'(TAPS))
            rd_tap = TAP_W'(rd_tap_sum - (TAP_W+1)'(TAPS));
        else
            rd_tap = rd_tap_sum[TAP_W-1:0];
    end

    assign rd_addr = ADDR_W'(int'(ich_reg) * TAPS + int'(rd_tap));
    assign wr_addr = ADDR_W'(int'(ich_reg) * TAPS + int'(ipos_reg));
    assign wr_en   = (state_reg == S_MAC) && (k_reg == '0);

    // newest sample comes from the mixer register; older ones from memory,
    // zero for taps not yet written since reset
    always_comb
    begin
        priority if (k_reg == '0)
        begin
            op_re = mix_re_reg;
            op_im = mix_im_reg;
        end
        else if (k_reg <= ifill_reg)
        begin
            op_re = rd_data_reg[MIX_W-1:0];
            op_im = rd_data_reg[2*MIX_W-1:MIX_W];
        end
        else
        begin
            op_re = '0;
            op_im = '0;
        end
    end

    assign h      = H_TAB[ich_reg][k_reg];
    assign mul_re = op_re * h;
    assign mul_im = op_im * h;
    assign mul_re_ext = {{(OUT_BITS-MUL_W){mul_re_reg[MUL_W-1]}}, mul_re_reg};
    assign mul_im_ext = {{(OUT_BITS-MUL_W){mul_im_reg[MUL_W-1]}}, mul_im_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            dl_mem[wr_addr] <= {mix_im_reg, mix_re_reg};
        rd_data_reg <= dl_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            slot_reg    <= '0;
            phase_reg   <= '0;
            wpos_reg    <= '0;
            fill_reg    <= '0;
            mul_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (out_vld_reg && m_tready)
                out_vld_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        samp_reg  <= signed'(s_tdata[SAMPLE_BITS-1:0]);
                        ich_reg   <= slot_reg;
                        iph_reg   <= phase_reg;
                        ipos_reg  <= wpos_reg;
                        ifill_reg <= fill_reg;
                        if (slot_reg == CH_W'(CHANNELS - 1))
                        begin
                            slot_reg  <= '0;
                            phase_reg <= (phase_reg == PH_W'(PHASES - 1)) ?
                                         '0 : phase_reg + 1'b1;
                            wpos_reg  <= (wpos_reg == TAP_W'(TAPS - 1)) ?
                                         '0 : wpos_reg + 1'b1;
                            if (fill_reg != TAP_W'(TAPS - 1))
                                fill_reg <= fill_reg + 1'b1;
                        end
                        else
                        begin
                            slot_reg <= slot_reg + 1'b1;
                        end
                        state_reg <= S_MIX;
                    end
                end
                S_MIX:
                begin
                    mix_re_reg  <= prod_re[MIX_W-1:0];
                    mix_im_reg  <= prod_im[MIX_W-1:0];
                    k_reg       <= '0;
                    acc_re_reg  <= '0;
                    acc_im_reg  <= '0;
                    mul_vld_reg <= 1'b0;
                    state_reg   <= S_MAC;
                end
                S_MAC:
                begin
                    mul_re_reg  <= mul_re;
                    mul_im_reg  <= mul_im;
                    mul_vld_reg <= 1'b1;
                    if (mul_vld_reg)
                    begin
                        acc_re_reg <= acc_re_reg + mul_re_ext;
                        acc_im_reg <= acc_im_reg + mul_im_ext;
                    end
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == TAP_W'(TAPS - 1))
                        state_reg <= S_TAIL;
                end
                S_TAIL:
                begin
                    acc_re_reg  <= acc_re_reg + mul_re_ext;
                    acc_im_reg  <= acc_im_reg + mul_im_ext;
                    mul_vld_reg <= 1'b0;
                    state_reg   <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_vld_reg || m_tready)
                    begin
                        out_vld_reg  <= 1'b1;
                        out_re_reg   <= acc_re_reg;
                        out_im_reg   <= acc_im_reg;
                        out_ch_reg   <= ich_reg;
                        out_last_reg <= (ich_reg == CH_W'(CHANNELS - 1));
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = DOUT_W'({out_im_reg, out_re_reg});
    assign m_tuser  = out_ch_reg;
    assign m_tlast  = out_last_reg;

    // frame marker tracks the channel number
    a_last_matches_channel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == CH_W'(CHANNELS - 1))))
        else $error("m_tlast does not match channel");

    // one item in flight at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_tready)
        else $error("second item accepted while busy");

    // write-back of the newest sample never hits the entry being read
    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (rd_addr != wr_addr))
        else $error("delay-line read and write on same entry");

    // pointers stay inside the delay line
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wpos_reg <= TAP_W'(TAPS - 1)) && (fill_reg <= TAP_W'(TAPS - 1)))
        else $error("frame pointer or fill count out of range");

    // end of frame wraps the slot and advances the mixer phase
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && slot_reg == CH_W'(CHANNELS - 1)) |=>
        (slot_reg == '0 && phase_reg == PH_W'($past(phase_reg) + 1'b1)))
        else $error("frame wrap did not advance phase");

endmodule
